@@ design/assert_macros.svh @@
// Assertion macros shared by the checker files.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in the same cycle as its trigger.
`define BBFC_ASSERT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("box contact check failed");

// Property holds in the cycle after its trigger.
`define BBFC_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("box contact check failed");

`endif

@@ design/bbfc_pkg.sv @@
// Shared types and constants for the box-box face contact pipeline.
// No dependencies.
package bbfc_pkg;

    localparam int COMP_BITS_DEF = 16;
    localparam int FW            = 48;
    localparam int DEPTH_W       = 16;

    typedef struct packed {
        logic [FW-1:0] a_center;
        logic [FW-1:0] a_axis_x;
        logic [FW-1:0] a_axis_y;
        logic [FW-1:0] a_axis_z;
        logic [FW-1:0] a_half_size;
        logic [FW-1:0] b_center;
        logic [FW-1:0] b_axis_x;
        logic [FW-1:0] b_axis_y;
        logic [FW-1:0] b_axis_z;
        logic [FW-1:0] b_half_size;
    } box_in_t;

    typedef struct packed {
        logic               hit;
        logic               face_owner;
        logic [1:0]         face_axis;
        logic [DEPTH_W-1:0] depth;
        logic [FW-1:0]      contact_normal;
        logic [FW-1:0]      contact_point;
    } contact_out_t;

    // Separating axis outcome handed from the overlap test to the contact stage.
    typedef struct packed {
        logic       hit;
        logic       owner;
        logic [1:0] axis;
    } sel_t;

endpackage

@@ design/bbfc_overlap.sv @@
// Face axis overlap test: three stages of dot products, projections and min search.
// Depends on bbfc_pkg.
module bbfc_overlap #(
    parameter int CB = bbfc_pkg::COMP_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  bbfc_pkg::box_in_t            in_item,
    output logic                         out_valid,
    output bbfc_pkg::box_in_t            out_item,
    output bbfc_pkg::sel_t               out_sel,
    output logic [bbfc_pkg::DEPTH_W-1:0] out_depth
);
    import bbfc_pkg::*;

    localparam int VW  = 3 * CB;
    localparam int AXF = CB - 2;
    localparam int DW  = 2 * CB + 2;
    localparam int MW  = CB + 2;
    localparam int PJW = 2 * CB + 5;
    localparam int CW  = 2 * CB + 3;
    localparam int PW  = 2 * CB + 7;

    function automatic logic [CB-1:0] comp(input logic [FW-1:0] v, input int i);
        logic [VW+FW-1:0] t;
        t = {{VW{1'b0}}, v};
        return t[i*CB +: CB];
    endfunction

    // stage 1: axis-axis dots and center offset
    logic signed [CB-1:0] ax6 [6][3];
    logic signed [DW-1:0] dd_next [6][6];
    logic signed [CB:0]   d_next [3];
    logic signed [DW-1:0] dd_reg [6][6];
    logic signed [CB:0]   d_reg [3];
    box_in_t              item1_reg;
    logic                 v1_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ax6[0][c] = comp(in_item.a_axis_x, c);
            ax6[1][c] = comp(in_item.a_axis_y, c);
            ax6[2][c] = comp(in_item.a_axis_z, c);
            ax6[3][c] = comp(in_item.b_axis_x, c);
            ax6[4][c] = comp(in_item.b_axis_y, c);
            ax6[5][c] = comp(in_item.b_axis_z, c);
            d_next[c] = (CB+1)'($signed(comp(in_item.b_center, c)))
                      - (CB+1)'($signed(comp(in_item.a_center, c)));
        end
        for (int j = 0; j < 6; j++)
            for (int l = 0; l < 6; l++)
                dd_next[j][l] = DW'(ax6[j][0]) * DW'(ax6[l][0])
                              + DW'(ax6[j][1]) * DW'(ax6[l][1])
                              + DW'(ax6[j][2]) * DW'(ax6[l][2]);
    end

    // stage 2: projected half lengths and center projection
    logic signed [CB-1:0] ax1 [6][3];
    logic [CB-1:0]        h1 [6];
    logic [PJW-1:0]       proj_next [6];
    logic signed [CW-1:0] cd_next [6];
    logic [PJW-1:0]       proj_reg [6];
    logic signed [CW-1:0] cd_reg [6];
    box_in_t              item2_reg;
    logic                 v2_reg;

    always_comb
    begin
        logic [DW-1:0] m;
        logic [MW-1:0] sh;
        for (int c = 0; c < 3; c++)
        begin
            ax1[0][c] = comp(item1_reg.a_axis_x, c);
            ax1[1][c] = comp(item1_reg.a_axis_y, c);
            ax1[2][c] = comp(item1_reg.a_axis_z, c);
            ax1[3][c] = comp(item1_reg.b_axis_x, c);
            ax1[4][c] = comp(item1_reg.b_axis_y, c);
            ax1[5][c] = comp(item1_reg.b_axis_z, c);
            h1[c]     = comp(item1_reg.a_half_size, c);
            h1[c+3]   = comp(item1_reg.b_half_size, c);
        end
        for (int l = 0; l < 6; l++)
        begin
            proj_next[l] = '0;
            for (int j = 0; j < 6; j++)
            begin
                m  = dd_reg[j][l] < 0 ? DW'(-dd_reg[j][l]) : DW'(dd_reg[j][l]);
                sh = MW'(m >> AXF);
                proj_next[l] = proj_next[l] + PJW'(h1[j]) * PJW'(sh);
            end
            cd_next[l] = CW'(d_reg[0]) * CW'(ax1[l][0])
                       + CW'(d_reg[1]) * CW'(ax1[l][1])
                       + CW'(d_reg[2]) * CW'(ax1[l][2]);
        end
    end

    // stage 3: penetrations, first minimum wins ties
    logic signed [PW-1:0] pen [6];
    logic signed [PW-1:0] best;
    logic [2:0]           best_idx;
    logic                 hit;
    logic [PW-1:0]        dsh;
    sel_t                 sel_next;
    logic [DEPTH_W-1:0]   depth_next;
    sel_t                 sel_reg;
    logic [DEPTH_W-1:0]   depth_reg;
    box_in_t              item3_reg;
    logic                 v3_reg;

    always_comb
    begin
        logic signed [PW-1:0] pp;
        logic signed [PW-1:0] pm;
        logic [CW-1:0]        cm;
        hit = 1'b1;
        for (int l = 0; l < 6; l++)
        begin
            cm = cd_reg[l] < 0 ? CW'(-cd_reg[l]) : CW'(cd_reg[l]);
            pp = PW'(proj_reg[l]);
            pm = PW'(cm);
            pen[l] = pp - pm;
            if (pen[l] < 0)
                hit = 1'b0;
        end
        best     = pen[0];
        best_idx = 3'd0;
        for (int l = 1; l < 6; l++)
            if (pen[l] < best)
            begin
                best     = pen[l];
                best_idx = 3'(l);
            end
        dsh = PW'(best >>> AXF);
        sel_next   = '0;
        depth_next = '0;
        if (hit)
        begin
            sel_next.hit   = 1'b1;
            sel_next.owner = best_idx >= 3'd3;
            sel_next.axis  = best_idx >= 3'd3 ? 2'(best_idx - 3'd3) : best_idx[1:0];
            depth_next     = |dsh[PW-1:DEPTH_W] ? {DEPTH_W{1'b1}} : dsh[DEPTH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item1_reg <= in_item;
            dd_reg    <= dd_next;
            d_reg     <= d_next;
            item2_reg <= item1_reg;
            proj_reg  <= proj_next;
            cd_reg    <= cd_next;
            item3_reg <= item2_reg;
            sel_reg   <= sel_next;
            depth_reg <= depth_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item3_reg;
    assign out_sel   = sel_reg;
    assign out_depth = depth_reg;

endmodule

@@ design/bbfc_contact.sv @@
// Contact normal and deepest vertex: three stages after the axis choice.
// Depends on bbfc_pkg.
module bbfc_contact #(
    parameter int CB = bbfc_pkg::COMP_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  bbfc_pkg::box_in_t            in_item,
    input  bbfc_pkg::sel_t               in_sel,
    input  logic [bbfc_pkg::DEPTH_W-1:0] in_depth,
    output logic                         out_valid,
    output bbfc_pkg::contact_out_t       out_item
);
    import bbfc_pkg::*;

    localparam int VW  = 3 * CB;
    localparam int AXF = CB - 2;
    localparam int NW  = 2 * CB + 4;
    localparam int TW  = 2 * CB + 4;

    localparam logic signed [CB-1:0] SMAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] SMIN = {1'b1, {(CB-1){1'b0}}};

    function automatic logic [CB-1:0] comp(input logic [FW-1:0] v, input int i);
        logic [VW+FW-1:0] t;
        t = {{VW{1'b0}}, v};
        return t[i*CB +: CB];
    endfunction

    function automatic logic [FW-1:0] pack(input logic [VW-1:0] v);
        logic [VW+FW-1:0] t;
        t = {{FW{1'b0}}, v};
        return t[FW-1:0];
    endfunction

    // axes of the other box as seen from the chosen owner
    logic signed [CB-1:0] oax [3][3];

    // stage 4: normal candidate and its orientation test
    logic signed [CB-1:0] n_next [3];
    logic signed [CB+1:0] tc [3];
    logic signed [NW-1:0] ndt;
    logic signed [CB-1:0] n_reg [3];
    logic                 flip_reg;
    box_in_t              item4_reg;
    sel_t                 sel4_reg;
    logic [DEPTH_W-1:0]   depth4_reg;
    logic                 v4_reg;

    always_comb
    begin
        logic signed [CB-1:0] own [3][3];
        for (int c = 0; c < 3; c++)
        begin
            own[0][c] = in_sel.owner ? comp(in_item.b_axis_x, c) : comp(in_item.a_axis_x, c);
            own[1][c] = in_sel.owner ? comp(in_item.b_axis_y, c) : comp(in_item.a_axis_y, c);
            own[2][c] = in_sel.owner ? comp(in_item.b_axis_z, c) : comp(in_item.a_axis_z, c);
            tc[c] = (CB+2)'($signed(comp(in_item.b_center, c)))
                  - (CB+2)'($signed(comp(in_item.a_center, c)));
            if (in_sel.owner)
                tc[c] = -tc[c];
        end
        for (int c = 0; c < 3; c++)
        begin
            unique case (in_sel.axis)
                2'd0:    n_next[c] = own[0][c];
                2'd1:    n_next[c] = own[1][c];
                default: n_next[c] = own[2][c];
            endcase
        end
        ndt = NW'(n_next[0]) * NW'(tc[0]) + NW'(n_next[1]) * NW'(tc[1])
            + NW'(n_next[2]) * NW'(tc[2]);
    end

    // stage 5: flip normal away from the other box, pick vertex signs
    logic signed [CB-1:0] nf [3];
    logic signed [NW-1:0] sdot [3];
    logic signed [CB-1:0] nf_reg [3];
    logic [2:0]           neg_reg;
    logic [2:0]           neg_next;
    box_in_t              item5_reg;
    sel_t                 sel5_reg;
    logic [DEPTH_W-1:0]   depth5_reg;
    logic                 v5_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            oax[0][c] = sel4_reg.owner ? comp(item4_reg.a_axis_x, c)
                                       : comp(item4_reg.b_axis_x, c);
            oax[1][c] = sel4_reg.owner ? comp(item4_reg.a_axis_y, c)
                                       : comp(item4_reg.b_axis_y, c);
            oax[2][c] = sel4_reg.owner ? comp(item4_reg.a_axis_z, c)
                                       : comp(item4_reg.b_axis_z, c);
            if (!flip_reg)
                nf[c] = n_reg[c];
            else if (n_reg[c] == SMIN)
                nf[c] = SMAX;
            else
                nf[c] = -n_reg[c];
        end
        for (int k = 0; k < 3; k++)
        begin
            sdot[k] = NW'(nf[0]) * NW'(oax[k][0]) + NW'(nf[1]) * NW'(oax[k][1])
                    + NW'(nf[2]) * NW'(oax[k][2]);
            neg_next[k] = sdot[k] < 0;
        end
    end

    // stage 6: deepest vertex, floor by AXF bits back to the center format and saturate
    logic signed [CB-1:0] oax5 [3][3];
    logic signed [CB-1:0] oc5 [3];
    logic [CB-1:0]        oh5 [3];
    logic signed [TW-1:0] pt [3];
    logic [VW-1:0]        pt_pk;
    logic [VW-1:0]        n_pk;
    contact_out_t         out_next;
    contact_out_t         out_reg;
    logic                 v6_reg;

    always_comb
    begin
        logic signed [CB:0]   hk;
        logic signed [TW-1:0] ps;
        for (int c = 0; c < 3; c++)
        begin
            oc5[c] = sel5_reg.owner ? comp(item5_reg.a_center, c) : comp(item5_reg.b_center, c);
            oh5[c] = sel5_reg.owner ? comp(item5_reg.a_half_size, c)
                                    : comp(item5_reg.b_half_size, c);
            oax5[0][c] = sel5_reg.owner ? comp(item5_reg.a_axis_x, c)
                                        : comp(item5_reg.b_axis_x, c);
            oax5[1][c] = sel5_reg.owner ? comp(item5_reg.a_axis_y, c)
                                        : comp(item5_reg.b_axis_y, c);
            oax5[2][c] = sel5_reg.owner ? comp(item5_reg.a_axis_z, c)
                                        : comp(item5_reg.b_axis_z, c);
        end
        for (int c = 0; c < 3; c++)
        begin
            pt[c] = TW'(oc5[c]) <<< AXF;
            for (int k = 0; k < 3; k++)
            begin
                hk = (CB+1)'({1'b0, oh5[k]});
                if (neg_reg[k])
                    hk = -hk;
                pt[c] = pt[c] + TW'(hk) * TW'(oax5[k][c]);
            end
            ps = pt[c] >>> AXF;
            if (ps > TW'(SMAX))
                pt_pk[c*CB +: CB] = SMAX;
            else if (ps < TW'(SMIN))
                pt_pk[c*CB +: CB] = SMIN;
            else
                pt_pk[c*CB +: CB] = ps[CB-1:0];
            n_pk[c*CB +: CB] = nf_reg[c];
        end
        out_next = '0;
        if (sel5_reg.hit)
        begin
            out_next.hit            = 1'b1;
            out_next.face_owner     = sel5_reg.owner;
            out_next.face_axis      = sel5_reg.axis;
            out_next.depth          = depth5_reg;
            out_next.contact_normal = pack(n_pk);
            out_next.contact_point  = pack(pt_pk);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg      <= n_next;
            flip_reg   <= ndt > 0;
            item4_reg  <= in_item;
            sel4_reg   <= in_sel;
            depth4_reg <= in_depth;
            nf_reg     <= nf;
            neg_reg    <= neg_next;
            item5_reg  <= item4_reg;
            sel5_reg   <= sel4_reg;
            depth5_reg <= depth4_reg;
            out_reg    <= out_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_item  = out_reg;

endmodule

@@ design/box_box_face_contact.sv @@
// Box-box face contact engine: one pair of oriented boxes per cycle in while not stalled,
// one contact result per pair out. Six register stages, all advanced together, lead
// from an accepted pair to the output register. The whole pipeline holds while the
// output register is full and not taken, so in_ready follows out_ready whenever a
// result waits; with out_ready high an item enters every cycle.
// Depends on bbfc_pkg, bbfc_overlap and bbfc_contact.
module box_box_face_contact #(
    parameter int COMP_BITS = bbfc_pkg::COMP_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  bbfc_pkg::box_in_t      in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output bbfc_pkg::contact_out_t out_item
);
    import bbfc_pkg::*;

    logic               en;
    logic               ov_valid;
    box_in_t            ov_item;
    sel_t               ov_sel;
    logic [DEPTH_W-1:0] ov_depth;

    // advance when the output slot is free or being emptied
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    bbfc_overlap #(.CB(COMP_BITS)) u_overlap (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid && in_ready),
        .in_item   (in_item),
        .out_valid (ov_valid),
        .out_item  (ov_item),
        .out_sel   (ov_sel),
        .out_depth (ov_depth)
    );

    bbfc_contact #(.CB(COMP_BITS)) u_contact (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ov_valid),
        .in_item   (ov_item),
        .in_sel    (ov_sel),
        .in_depth  (ov_depth),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule

@@ design/bbfc_checker.sv @@
// Port-level checks for box_box_face_contact, attached by bind.
// Depends on bbfc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bbfc_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input bbfc_pkg::box_in_t      in_item,
    input logic                   out_valid,
    input logic                   out_ready,
    input bbfc_pkg::contact_out_t out_item
);
    `BBFC_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_item))
    `BBFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))
    `BBFC_ASSERT(a_ready_when_empty, !out_valid, in_ready)
    `BBFC_ASSERT(a_miss_is_zero, out_valid && !out_item.hit, out_item == '0)
    `BBFC_ASSERT(a_axis_range, out_valid && out_item.hit, out_item.face_axis != 2'd3)

endmodule

bind box_box_face_contact bbfc_checker u_bbfc_checker (.*);
